// ----- rtl/cse_pkg.sv -----
// Package for the cubic spline evaluator: widths, limits, shared types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package cse_pkg;
   localparam int MaxKnotsDefault = 64;
   localparam int FracBitsDefault = 16;
   localparam int DataWidth = 32;
   localparam int IdxWidth = 6;
   localparam int CountWidth = 7;
   localparam int AccWidth = 192;
   localparam logic OpLoad = 1'b0;
   localparam logic OpQuery = 1'b1;

   typedef struct packed {
      logic                 op;
      logic [IdxWidth-1:0]  knot_index;
      logic [31:0]          knot_pos;
      logic [31:0]          knot_value;
      logic [31:0]          coef_lin;
      logic [31:0]          coef_quad;
      logic [31:0]          coef_cubic;
      logic [31:0]          query_pos;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EDGE0, ST_EDGE1, ST_SEARCH, ST_FETCH, ST_MUL, ST_ADD, ST_DONE
   } state_type;
endpackage

// ----- rtl/cse_queue.sv -----
// Two-entry queue between the front and the back of the spline evaluator.
// Depends on cse_pkg.
`timescale 1ns / 1ps
module cse_queue
   import cse_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output item_type pop_data
);
   item_type   mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full = cnt_ff[1];
   assign not_empty = cnt_ff != 2'd0;
   assign pop_data = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ----- rtl/cse_front.sv -----
// Front end: takes request transactions and pushes them into the queue.
// Depends on cse_pkg.
`timescale 1ns / 1ps
module cse_front
   import cse_pkg::*;
(
   input  logic     req_valid,
   output logic     req_stall,
   input  item_type req_item,
   input  logic     q_full,
   output logic     q_push,
   output item_type q_data
);
   assign req_stall = q_full;
   assign q_push = req_valid && !q_full;
   assign q_data = req_item;
endmodule

// ----- rtl/cse_back.sv -----
// Back end: knot table memories, binary search and Horner evaluation.
// Depends on cse_pkg.
`timescale 1ns / 1ps
module cse_back
   import cse_pkg::*;
#(
   parameter int MAX_KNOTS = MaxKnotsDefault,
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CountWidth-1:0] knot_count,
   input  logic                  q_valid,
   input  item_type              q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [31:0]           rsp_value,
   output logic [31:0]           rsp_slope,
   output logic [IdxWidth-1:0]   rsp_interval,
   output logic                  rsp_out_of_range
);
   localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
   localparam int NW = AW + 1;
   localparam int Limbs = AccWidth / 32;
   localparam int LimbW = $clog2(Limbs);

   logic [31:0] pos_mem [MAX_KNOTS];
   logic [31:0] y_mem [MAX_KNOTS];
   logic [31:0] b_mem [MAX_KNOTS];
   logic [31:0] c_mem [MAX_KNOTS];
   logic [31:0] d_mem [MAX_KNOTS];

   state_type state_ff, state_in;
   logic [AW-1:0] raddr;
   logic [31:0] rpos_ff, ry_ff, rb_ff, rc_ff, rd_ff;
   logic [NW-1:0] n_ff, n_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [31:0] z_ff, z_in;
   logic [31:0] t_ff, t_in;
   logic [AccWidth-1:0] av_ff, av_in, as_ff, as_in;
   logic [1:0] step_ff, step_in;
   logic [LimbW-1:0] limb_ff, limb_in;
   logic [31:0] cv_ff, cv_in, cs_ff, cs_in;
   logic [63:0] pv, ps;
   logic [31:0] v_ff, v_in, s_ff, s_in;
   logic [IdxWidth-1:0] iv_ff, iv_in;
   logic oor_ff, oor_in, ov_ff, ov_in;
   logic [NW-1:0] mid;
   logic [CountWidth:0] nc;
   logic load_ok;

   function automatic logic [31:0] sat_shr(input logic [AccWidth-1:0] a, input int s);
      logic [AccWidth-1:0] r;
      logic ok;
      r = $signed(a) >>> s;
      ok = (r[AccWidth-1:31] == '0) || (r[AccWidth-1:31] == '1);
      if (ok) begin
         return r[31:0];
      end
      return a[AccWidth-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

   assign mid = NW'((({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1));
   assign load_ok = {1'b0, q_data.knot_index} < (IdxWidth+1)'(MAX_KNOTS)
                    || MAX_KNOTS > 64;

   always_comb begin
      raddr = lo_ff[AW-1:0];
      case (state_ff)
         ST_IDLE:   raddr = '0;
         ST_EDGE0:  raddr = AW'(n_ff - NW'(1));
         ST_SEARCH: raddr = mid[AW-1:0];
         default:   raddr = lo_ff[AW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid && !ov_ff && q_data.op == OpLoad && load_ok) begin
         pos_mem[AW'(q_data.knot_index)] <= q_data.knot_pos;
         y_mem[AW'(q_data.knot_index)] <= q_data.knot_value;
         b_mem[AW'(q_data.knot_index)] <= q_data.coef_lin;
         c_mem[AW'(q_data.knot_index)] <= q_data.coef_quad;
         d_mem[AW'(q_data.knot_index)] <= q_data.coef_cubic;
      end
      rpos_ff <= pos_mem[raddr];
      ry_ff <= y_mem[raddr];
      rb_ff <= b_mem[raddr];
      rc_ff <= c_mem[raddr];
      rd_ff <= d_mem[raddr];
   end

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      z_in = z_ff;
      t_in = t_ff;
      av_in = av_ff;
      as_in = as_ff;
      step_in = step_ff;
      limb_in = limb_ff;
      cv_in = cv_ff;
      cs_in = cs_ff;
      pv = '0;
      ps = '0;
      v_in = v_ff;
      s_in = s_ff;
      iv_in = iv_ff;
      oor_in = oor_ff;
      ov_in = ov_ff && rsp_stall;
      q_pop = 1'b0;
      nc = {1'b0, knot_count};
      if (nc < (CountWidth+1)'(2)) begin
         nc = (CountWidth+1)'(2);
      end
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && !ov_ff) begin
               q_pop = 1'b1;
               if (q_data.op == OpQuery) begin
                  z_in = q_data.query_pos;
                  if (int'(nc) > MAX_KNOTS) begin
                     n_in = NW'(MAX_KNOTS);
                  end else begin
                     n_in = NW'(nc);
                  end
                  state_in = ST_EDGE0;
               end
            end
         end
         ST_EDGE0: begin
            state_in = ST_EDGE1;
            oor_in = !($signed(z_ff) > $signed(rpos_ff));
         end
         ST_EDGE1: begin
            lo_in = '0;
            hi_in = n_ff - NW'(1);
            if (oor_ff || !($signed(z_ff) < $signed(rpos_ff))) begin
               oor_in = 1'b1;
               v_in = '0;
               s_in = '0;
               iv_in = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (hi_ff - lo_ff > NW'(1)) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_MUL;
               step_in = '0;
            end
         end
         ST_FETCH: begin
            if ($signed(z_ff) > $signed(rpos_ff)) begin
               lo_in = mid;
            end else begin
               hi_in = mid;
            end
            state_in = ST_SEARCH;
         end
         ST_MUL: begin
            if (step_ff == 2'd0) begin
               t_in = z_ff - rpos_ff;
               av_in = AccWidth'($signed(rd_ff));
               as_in = (AccWidth'($signed(rd_ff)) << 1) + AccWidth'($signed(rd_ff));
               limb_in = '0;
               cv_in = '0;
               cs_in = '0;
               state_in = ST_ADD;
            end else begin
               pv = 64'(av_ff[32*limb_ff +: 32]) * 64'(t_ff) + 64'(cv_ff);
               ps = 64'(as_ff[32*limb_ff +: 32]) * 64'(t_ff) + 64'(cs_ff);
               av_in[32*limb_ff +: 32] = pv[31:0];
               if (step_ff != 2'd3) begin
                  as_in[32*limb_ff +: 32] = ps[31:0];
               end
               cv_in = pv[63:32];
               cs_in = ps[63:32];
               limb_in = limb_ff + LimbW'(1);
               if (limb_ff == LimbW'(Limbs - 1)) begin
                  limb_in = '0;
                  cv_in = '0;
                  cs_in = '0;
                  state_in = ST_ADD;
               end
            end
         end
         ST_ADD: begin
            step_in = step_ff + 2'd1;
            state_in = ST_MUL;
            case (step_ff)
               2'd1: begin
                  av_in = av_ff + (AccWidth'($signed(rc_ff)) << FRAC_BITS);
                  as_in = as_ff + (AccWidth'($signed(rc_ff)) << (FRAC_BITS + 1));
               end
               2'd2: begin
                  av_in = av_ff + (AccWidth'($signed(rb_ff)) << (2 * FRAC_BITS));
                  as_in = as_ff + (AccWidth'($signed(rb_ff)) << (2 * FRAC_BITS));
               end
               2'd3: begin
                  av_in = av_ff + (AccWidth'($signed(ry_ff)) << (3 * FRAC_BITS));
                  v_in = sat_shr(av_in, 3 * FRAC_BITS);
                  s_in = sat_shr(as_ff, 2 * FRAC_BITS);
                  iv_in = IdxWidth'(lo_ff);
                  oor_in = 1'b0;
                  state_in = ST_DONE;
               end
               default: ;
            endcase
         end
         ST_DONE: begin
            ov_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      z_ff <= z_in;
      t_ff <= t_in;
      av_ff <= av_in;
      as_ff <= as_in;
      step_ff <= step_in;
      limb_ff <= limb_in;
      cv_ff <= cv_in;
      cs_ff <= cs_in;
      v_ff <= v_in;
      s_ff <= s_in;
      iv_ff <= iv_in;
      oor_ff <= oor_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_value = v_ff;
   assign rsp_slope = s_ff;
   assign rsp_interval = iv_ff;
   assign rsp_out_of_range = oor_ff;
endmodule

// ----- rtl/cubic_spline_eval_derivative.sv -----
// Top level of the cubic spline evaluator with first derivative.
// Depends on cse_pkg, cse_front, cse_queue and cse_back.
//   Channel   Direction  Handshake        Payload
//   req_      in         valid / stall    op, knot fields, query position
//   rsp_      out        valid / stall    value, slope, interval, flag
//   csr_      in         valid / ready    knot count
// A load is written to the knot tables as the back end takes it. A query is taken,
// passes the edge checks, the binary search and the Horner steps, with each multiply
// by t done as six 32x32 limb products, and has its result registered; an out-of-range
// query goes from the edge checks straight to the result. A result holds the back end
// until it is taken. Reset is synchronous and clears control state only.
// A two-entry queue lets requests be taken while the back end works or is stalled.
`timescale 1ns / 1ps
module cubic_spline_eval_derivative
   import cse_pkg::*;
#(
   parameter int MAX_KNOTS = MaxKnotsDefault,
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CountWidth-1:0] csr_knot_count,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic [IdxWidth-1:0]   req_knot_index,
   input  logic [31:0]           req_knot_pos,
   input  logic [31:0]           req_knot_value,
   input  logic [31:0]           req_coef_lin,
   input  logic [31:0]           req_coef_quad,
   input  logic [31:0]           req_coef_cubic,
   input  logic [31:0]           req_query_pos,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [31:0]           rsp_value,
   output logic [31:0]           rsp_slope,
   output logic [IdxWidth-1:0]   rsp_interval,
   output logic                  rsp_out_of_range
);
   logic [CountWidth-1:0] count_ff;
   item_type req_item, q_in, q_out;
   logic q_push, q_full, q_ne, q_pop;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountWidth'(2);
      end else if (csr_valid) begin
         count_ff <= csr_knot_count;
      end
   end

   assign req_item = '{op: req_op, knot_index: req_knot_index, knot_pos: req_knot_pos,
                       knot_value: req_knot_value, coef_lin: req_coef_lin,
                       coef_quad: req_coef_quad, coef_cubic: req_coef_cubic,
                       query_pos: req_query_pos};

   cse_front u_front (
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .q_full(q_full), .q_push(q_push), .q_data(q_in)
   );

   cse_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .not_empty(q_ne), .pop_data(q_out)
   );

   cse_back #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .knot_count(count_ff), .q_valid(q_ne),
      .q_data(q_out), .q_pop(q_pop), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp_value(rsp_value), .rsp_slope(rsp_slope),
      .rsp_interval(rsp_interval), .rsp_out_of_range(rsp_out_of_range)
   );
endmodule
